[rtl/ffpa_pkg.sv]
// ffpa_pkg: shared constants, types and helpers for the first-fit partition allocator.
// No dependencies; every other file of the block imports it.
package ffpa_pkg;

	localparam int FREE_ENTRIES = 16;
	localparam int JOB_SLOTS    = 16;
	localparam int ADDR_BITS    = 16;

	localparam int REQ_W    = 2;
	localparam int JOBID_W  = 4;
	localparam int FIELD_W  = 16;
	localparam int STATUS_W = 3;
	localparam int FREE_W   = 5;

	localparam int POS_W = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(FREE_ENTRIES + 1);
	localparam int JOB_W = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;

	localparam int SLOT_CALC_W = ((JOBID_W > JOB_W) ? JOBID_W : JOB_W) + 1;
	localparam int SLOT_STEPS  = (1 << JOBID_W) / JOB_SLOTS + 1;

	typedef logic [ADDR_BITS-1:0] addr_t;
	typedef logic [ADDR_BITS:0]   wide_t;

	typedef enum logic [REQ_W-1:0] {
		REQ_LOAD,
		REQ_ALLOC,
		REQ_RELEASE
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK,
		ST_NO_FIT,
		ST_NEVER,
		ST_RELEASED,
		ST_FULL
	} status_t;

	typedef enum logic [1:0] {
		JS_NEVER,
		JS_ALLOC,
		JS_DONE
	} job_state_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_SHIFT_UP,
		OP_SHIFT_DOWN,
		OP_WRITE,
		OP_SPLIT,
		OP_MERGE_HEAD,
		OP_MERGE_TAIL
	} cell_op_t;

	typedef struct packed {
		logic  valid;
		addr_t start;
		addr_t len;
	} cell_data_t;

	typedef struct packed {
		logic hit;
		logic exact;
		logic tail;
		logic head;
	} cell_flags_t;

	// job id modulo slot count, by repeated subtraction on a narrow value
	function automatic logic [JOB_W-1:0] job_slot(input logic [JOBID_W-1:0] id);
		logic [SLOT_CALC_W-1:0] v;
		v = SLOT_CALC_W'(id);
		for (int i = 0; i < SLOT_STEPS; i++) begin
			if (v >= SLOT_CALC_W'(JOB_SLOTS)) begin
				v = v - SLOT_CALC_W'(JOB_SLOTS);
			end
		end
		return JOB_W'(v);
	endfunction

endpackage

[rtl/ffpa_if.sv]
// ffpa_req_if / ffpa_rsp_if: valid/ready channels for request and response words.
// Depends on ffpa_pkg for field widths.
interface ffpa_req_if;
	import ffpa_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [REQ_W-1:0]     req_type;
	logic [JOBID_W-1:0]   job_id;
	logic [FIELD_W-1:0]   region_start;
	logic [FIELD_W-1:0]   region_length;

	modport source (output valid, output req_type, output job_id, output region_start,
		output region_length, input ready);
	modport sink (input valid, input req_type, input job_id, input region_start,
		input region_length, output ready);
endinterface

interface ffpa_rsp_if;
	import ffpa_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [STATUS_W-1:0]  status;
	logic [FIELD_W-1:0]   granted_start;
	logic [FREE_W-1:0]    free_entries;

	modport source (output valid, output status, output granted_start,
		output free_entries, input ready);
	modport sink (input valid, input status, input granted_start,
		input free_entries, output ready);
endinterface

[rtl/first_fit_partition_allocator.sv]
// first_fit_partition_allocator: first-fit region allocator with coalescing release.
// Depends on ffpa_pkg, ffpa_if (ffpa_req_if, ffpa_rsp_if) and ffpa_cell.
//
//   channel  dir  interface    word
//   req      in   ffpa_req_if  req_type, job_id, region_start, region_length
//   rsp      out  ffpa_rsp_if  status, granted_start, free_entries
//
// Each request passes through accept, cell compare, first-hit pick and table update, in that order.
// The pick is a priority search over the registered hit flags of the cell row.
// One request is in flight at a time; req.ready is high only between requests.
// The response sits in an output register; a new request is accepted while it waits,
// and the update cycle holds until that register is free.
// Reset clears the table valid bits, the entry count and all job states.
module first_fit_partition_allocator (
	input  logic       clk,
	input  logic       arst_n,
	ffpa_req_if.sink   req,
	ffpa_rsp_if.source rsp
);
	import ffpa_pkg::*;

	typedef enum logic [1:0] {
		IDLE,
		COMPARE,
		PICK,
		APPLY
	} fsm_t;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_INSERT,
		ACT_SPLIT,
		ACT_REMOVE,
		ACT_MERGE_HEAD,
		ACT_MERGE_TAIL,
		ACT_MERGE_BOTH
	} act_t;

	typedef struct packed {
		act_t             act;
		logic [POS_W-1:0] pos;
		status_t          status;
		addr_t            granted;
	} plan_t;

	fsm_t             state_q;
	logic             rsp_valid_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_next;
	status_t          rsp_status_q;
	addr_t            rsp_granted_q;
	logic [CNT_W-1:0] rsp_cnt_q;

	req_t             req_q;
	logic [JOB_W-1:0] idx_q;
	addr_t            rs_q;
	addr_t            rl_q;
	addr_t            js_q;
	addr_t            jl_q;
	job_state_t       jst_q;

	addr_t            job_start_mem [JOB_SLOTS];
	addr_t            job_len_mem [JOB_SLOTS];
	job_state_t       job_st_q [JOB_SLOTS];

	plan_t            plan_q;
	plan_t            plan_d;

	logic             accept;
	logic             cmp_en;
	logic             pick_en;
	logic             apply_go;
	logic             full;
	logic [JOB_W-1:0] acc_idx;

	addr_t            opnd_start;
	addr_t            opnd_len;
	wide_t            opnd_end;

	cell_op_t         cell_op [FREE_ENTRIES];
	cell_data_t       cell_d [FREE_ENTRIES];
	cell_flags_t      cell_f [FREE_ENTRIES];
	logic             cell_mnext [FREE_ENTRIES];

	logic             hit_any;
	logic [POS_W-1:0] hit_pos;
	cell_flags_t      sel_f;
	addr_t            sel_start;
	logic             sel_mnext;
	logic [POS_W-1:0] ins_pos;

	assign accept   = req.valid && req.ready;
	assign cmp_en   = (state_q == COMPARE);
	assign pick_en  = (state_q == PICK);
	assign apply_go = (state_q == APPLY) && (!rsp_valid_q || rsp.ready);
	assign full     = (cnt_q == CNT_W'(FREE_ENTRIES));
	assign acc_idx  = job_slot(req.job_id);

	assign opnd_start = (req_q == REQ_RELEASE) ? js_q : rs_q;
	assign opnd_len   = (req_q == REQ_RELEASE) ? jl_q : rl_q;
	assign opnd_end   = {1'b0, js_q} + {1'b0, jl_q};

	// request latch and job record read
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_t'(req.req_type);
			idx_q <= acc_idx;
			rs_q  <= ADDR_BITS'(req.region_start);
			rl_q  <= ADDR_BITS'(req.region_length);
			js_q  <= job_start_mem[acc_idx];
			jl_q  <= job_len_mem[acc_idx];
			jst_q <= job_st_q[acc_idx];
		end
		if (apply_go && req_q == REQ_ALLOC) begin
			job_start_mem[idx_q] <= plan_q.granted;
			job_len_mem[idx_q]   <= rl_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < JOB_SLOTS; j++) begin
				job_st_q[j] <= JS_NEVER;
			end
		end else if (apply_go) begin
			if (req_q == REQ_ALLOC) begin
				job_st_q[idx_q] <= (plan_q.status == ST_OK) ? JS_ALLOC : JS_NEVER;
			end else if (req_q == REQ_RELEASE && plan_q.status == ST_OK) begin
				job_st_q[idx_q] <= JS_DONE;
			end
		end
	end

	// cell row
	for (genvar k = 0; k < FREE_ENTRIES; k++) begin : g_cell
		cell_data_t left_d;
		cell_data_t right_d;

		if (k == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_inner_l
			assign left_d = cell_d[k-1];
		end
		if (k == FREE_ENTRIES - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_inner_r
			assign right_d = cell_d[k+1];
		end

		ffpa_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.req_kind   (req_q),
			.cmp_en     (cmp_en),
			.pick_en    (pick_en),
			.op         (cell_op[k]),
			.opnd_start (opnd_start),
			.opnd_len   (opnd_len),
			.opnd_end   (opnd_end),
			.left_d     (left_d),
			.right_d    (right_d),
			.data       (cell_d[k]),
			.flags      (cell_f[k]),
			.mnext      (cell_mnext[k])
		);
	end

	// first hit in address order
	always_comb begin
		hit_any   = 1'b0;
		hit_pos   = '0;
		sel_f     = '0;
		sel_start = '0;
		sel_mnext = 1'b0;
		for (int k = FREE_ENTRIES - 1; k >= 0; k--) begin
			if (cell_f[k].hit) begin
				hit_any   = 1'b1;
				hit_pos   = POS_W'(k);
				sel_f     = cell_f[k];
				sel_start = cell_d[k].start;
				sel_mnext = cell_mnext[k];
			end
		end
	end

	assign ins_pos = hit_any ? hit_pos : POS_W'(cnt_q);

	always_comb begin
		plan_d.act     = ACT_NONE;
		plan_d.pos     = hit_pos;
		plan_d.status  = ST_OK;
		plan_d.granted = '0;
		unique case (req_q)
			REQ_LOAD: begin
				if (full) begin
					plan_d.status = ST_FULL;
				end else begin
					plan_d.act = ACT_INSERT;
					plan_d.pos = ins_pos;
				end
			end
			REQ_ALLOC: begin
				if (hit_any) begin
					plan_d.act     = sel_f.exact ? ACT_REMOVE : ACT_SPLIT;
					plan_d.granted = sel_start;
				end else begin
					plan_d.status = ST_NO_FIT;
				end
			end
			REQ_RELEASE: begin
				if (jst_q == JS_NEVER) begin
					plan_d.status = ST_NEVER;
				end else if (jst_q == JS_DONE) begin
					plan_d.status = ST_RELEASED;
				end else if (hit_any && sel_f.tail) begin
					plan_d.act     = sel_mnext ? ACT_MERGE_BOTH : ACT_MERGE_TAIL;
					plan_d.granted = js_q;
				end else if (hit_any && sel_f.head) begin
					plan_d.act     = ACT_MERGE_HEAD;
					plan_d.granted = js_q;
				end else if (full) begin
					plan_d.status = ST_FULL;
				end else begin
					plan_d.act     = ACT_INSERT;
					plan_d.pos     = ins_pos;
					plan_d.granted = js_q;
				end
			end
			default: begin
				plan_d.act = ACT_NONE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pick_en) begin
			plan_q <= plan_d;
		end
	end

	// per-cell operation from the plan
	always_comb begin
		for (int k = 0; k < FREE_ENTRIES; k++) begin
			cell_op[k] = OP_HOLD;
			if (apply_go) begin
				if (POS_W'(k) == plan_q.pos) begin
					unique case (plan_q.act)
						ACT_INSERT:     cell_op[k] = OP_WRITE;
						ACT_SPLIT:      cell_op[k] = OP_SPLIT;
						ACT_REMOVE:     cell_op[k] = OP_SHIFT_DOWN;
						ACT_MERGE_HEAD: cell_op[k] = OP_MERGE_HEAD;
						ACT_MERGE_TAIL,
						ACT_MERGE_BOTH: cell_op[k] = OP_MERGE_TAIL;
						default:        cell_op[k] = OP_HOLD;
					endcase
				end else if (POS_W'(k) > plan_q.pos) begin
					unique case (plan_q.act)
						ACT_INSERT:     cell_op[k] = OP_SHIFT_UP;
						ACT_REMOVE,
						ACT_MERGE_BOTH: cell_op[k] = OP_SHIFT_DOWN;
						default:        cell_op[k] = OP_HOLD;
					endcase
				end
			end
		end
	end

	always_comb begin
		unique case (plan_q.act)
			ACT_INSERT:     cnt_next = cnt_q + CNT_W'(1);
			ACT_REMOVE,
			ACT_MERGE_BOTH: cnt_next = cnt_q - CNT_W'(1);
			default:        cnt_next = cnt_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= IDLE;
			rsp_valid_q   <= 1'b0;
			cnt_q         <= '0;
			rsp_status_q  <= ST_OK;
			rsp_granted_q <= '0;
			rsp_cnt_q     <= '0;
		end else begin
			if (apply_go) begin
				rsp_valid_q   <= 1'b1;
				cnt_q         <= cnt_next;
				rsp_status_q  <= plan_q.status;
				rsp_granted_q <= plan_q.granted;
				rsp_cnt_q     <= cnt_next;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE:    if (accept) state_q <= COMPARE;
				COMPARE: state_q <= PICK;
				PICK:    state_q <= APPLY;
				APPLY:   if (apply_go) state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end

	assign req.ready         = (state_q == IDLE);
	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.granted_start = FIELD_W'(rsp_granted_q);
	assign rsp.free_entries  = FREE_W'(rsp_cnt_q);

endmodule

[rtl/ffpa_cell.sv]
// ffpa_cell: one free-table entry with its compare logic and neighbor shift paths.
// Depends on ffpa_pkg.
module ffpa_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ffpa_pkg::req_t        req_kind,
	input  logic                  cmp_en,
	input  logic                  pick_en,
	input  ffpa_pkg::cell_op_t    op,
	input  ffpa_pkg::addr_t       opnd_start,
	input  ffpa_pkg::addr_t       opnd_len,
	input  ffpa_pkg::wide_t       opnd_end,
	input  ffpa_pkg::cell_data_t  left_d,
	input  ffpa_pkg::cell_data_t  right_d,
	output ffpa_pkg::cell_data_t  data,
	output ffpa_pkg::cell_flags_t flags,
	output logic                  mnext
);
	import ffpa_pkg::*;

	logic        valid_q;
	addr_t       start_q;
	addr_t       len_q;
	addr_t       mlen_q;
	addr_t       tail_len_q;
	addr_t       tail_len_d;
	cell_flags_t flags_q;
	cell_flags_t flags_d;
	wide_t       end_w;
	wide_t       tail_end;

	assign end_w = {1'b0, start_q} + {1'b0, len_q};

	always_comb begin
		flags_d = '0;
		unique case (req_kind)
			REQ_LOAD: begin
				flags_d.hit = valid_q && (opnd_start <= start_q);
			end
			REQ_ALLOC: begin
				flags_d.hit   = valid_q && (opnd_len <= len_q);
				flags_d.exact = (opnd_len == len_q);
			end
			REQ_RELEASE: begin
				flags_d.tail = ({1'b0, opnd_start} == end_w);
				flags_d.head = (opnd_end == {1'b0, start_q});
				flags_d.hit  = valid_q && (flags_d.tail || flags_d.head ||
					(opnd_start < start_q));
			end
			default: begin
				flags_d = '0;
			end
		endcase
	end

	// merged region may also reach the next entry
	assign tail_end   = {1'b0, start_q} + {1'b0, mlen_q};
	assign mnext      = right_d.valid && (tail_end == {1'b0, right_d.start});
	assign tail_len_d = mnext ? addr_t'(mlen_q + right_d.len) : mlen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			unique case (op)
				OP_SHIFT_UP:   valid_q <= left_d.valid;
				OP_SHIFT_DOWN: valid_q <= right_d.valid;
				OP_WRITE:      valid_q <= 1'b1;
				default:       valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmp_en) begin
			flags_q <= flags_d;
			mlen_q  <= addr_t'(len_q + opnd_len);
		end
		if (pick_en) begin
			tail_len_q <= tail_len_d;
		end
		unique case (op)
			OP_SHIFT_UP: begin
				start_q <= left_d.start;
				len_q   <= left_d.len;
			end
			OP_SHIFT_DOWN: begin
				start_q <= right_d.start;
				len_q   <= right_d.len;
			end
			OP_WRITE: begin
				start_q <= opnd_start;
				len_q   <= opnd_len;
			end
			OP_SPLIT: begin
				start_q <= addr_t'(start_q + opnd_len);
				len_q   <= addr_t'(len_q - opnd_len);
			end
			OP_MERGE_HEAD: begin
				start_q <= opnd_start;
				len_q   <= mlen_q;
			end
			OP_MERGE_TAIL: begin
				len_q <= tail_len_q;
			end
			default: begin
				start_q <= start_q;
			end
		endcase
	end

	assign data.valid = valid_q;
	assign data.start = start_q;
	assign data.len   = len_q;
	assign flags      = flags_q;

endmodule

[rtl/ffpa_checker.sv]
// ffpa_checker: port-level checks on the allocator, attached by bind.
// Depends on ffpa_pkg and first_fit_partition_allocator.
module ffpa_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [ffpa_pkg::STATUS_W-1:0] rsp_status,
	input logic [ffpa_pkg::FIELD_W-1:0]  rsp_granted_start,
	input logic [ffpa_pkg::FREE_W-1:0]   rsp_free_entries
);
	import ffpa_pkg::*;

	// one request in flight
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while busy");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response word dropped before taken");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_free_entries <= FREE_W'(FREE_ENTRIES))
		else $error("free entry count out of range");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == ST_FULL |-> rsp_free_entries == FREE_W'(FREE_ENTRIES))
		else $error("table full reported with free space");

	a_fail_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ST_OK |-> rsp_granted_start == '0)
		else $error("granted start on failed request");

endmodule

bind first_fit_partition_allocator ffpa_checker u_ffpa_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_status        (rsp.status),
	.rsp_granted_start (rsp.granted_start),
	.rsp_free_entries  (rsp.free_entries)
);
